// ===== hw/rtl/rrts_pkg.sv =====
package rrts_pkg;

    // request codes carried on the input tuser
    typedef enum logic [2:0] {
        REQ_ENQ   = 3'd0,
        REQ_YIELD = 3'd1,
        REQ_BLOCK = 3'd2,
        REQ_EXIT  = 3'd3,
        REQ_QUERY = 3'd4
    } req_t;

    // per-thread state codes
    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_RUNNING = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_DEAD    = 2'd3
    } tstate_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DEAD = 2'd1,
        ST_DUP  = 2'd2
    } status_t;

    localparam int TID_W   = 4;
    localparam int COUNT_W = 5;

endpackage

// ===== hw/rtl/round_robin_thread_scheduler.sv =====
// Channel | Dir | Ports                            | Contents
// s_      | in  | s_tvalid s_tready s_tdata s_tuser | request item: kind, thread number
// m_      | out | m_tvalid m_tready m_tdata          | result item: status and scheduler view
//
// One request at a time: accept (memory reads), execute, then the result is
// loaded into the output register; a request that dispatches a new thread
// also passes the dispatch state, set by the single write port of the
// thread state memory (old and new running thread each need a write).
// Reset: aresetn synchronous, active low; the state table reads as blocked
// through per-entry valid bits, pointers and count clear at once.
// A stalled result holds in the output register; the next result waits for it.
module round_robin_thread_scheduler #(
    parameter int NUM_THREADS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] thread_id, [7:4] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [2] current_valid,
                                   // [6:3] current_thread, [11:7] queue_len,
                                   // [12] sched_empty, [15:13] zero
);

    localparam int IDX_W = $clog2(NUM_THREADS);
    localparam int CNT_W = $clog2(NUM_THREADS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DISP,
        S_RESP
    } fsm_t;

    // wrap a queue pointer at the queue depth
    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(NUM_THREADS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    fsm_t                          state_reg, state_next;
    rrts_pkg::req_t                req_reg, req_next;
    logic [rrts_pkg::TID_W-1:0]    tid_reg, tid_next;
    rrts_pkg::status_t             status_reg, status_next;
    logic                          run_valid_reg, run_valid_next;
    logic [rrts_pkg::TID_W-1:0]    run_id_reg, run_id_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [IDX_W-1:0]              tail_reg, tail_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [15:0]                   m_tdata_reg, m_tdata_next;

    // memories and their read registers
    rrts_pkg::tstate_t             state_mem [NUM_THREADS];
    logic [NUM_THREADS-1:0]        st_vld_reg;
    rrts_pkg::tstate_t             st_rd_reg;
    logic                          st_rd_vld_reg;
    logic [rrts_pkg::TID_W-1:0]    fifo_mem [NUM_THREADS];
    logic [rrts_pkg::TID_W-1:0]    fifo_rd_reg;

    // write ports
    logic                          st_we;
    logic [IDX_W-1:0]              st_waddr;
    rrts_pkg::tstate_t             st_wdata;
    logic                          fifo_we;
    logic [IDX_W-1:0]              fifo_waddr;
    logic [rrts_pkg::TID_W-1:0]    fifo_wdata;

    logic                          accept;
    logic [IDX_W-1:0]              in_idx;
    logic [IDX_W-1:0]              tid_idx;
    logic [IDX_W-1:0]              run_idx;
    rrts_pkg::tstate_t             eff_state;
    logic                          tid_ok;
    logic                          has_q;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_idx    = IDX_W'(s_tdata[rrts_pkg::TID_W-1:0]);
    assign tid_idx   = IDX_W'(tid_reg);
    assign run_idx   = IDX_W'(run_id_reg);
    assign eff_state = st_rd_vld_reg ? st_rd_reg : rrts_pkg::TS_BLOCKED;
    assign tid_ok    = int'(tid_reg) < NUM_THREADS;
    assign has_q     = (cnt_reg != '0);

    // thread state memory: one write, one registered read at accept
    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (accept) begin
            st_rd_reg     <= state_mem[in_idx];
            st_rd_vld_reg <= st_vld_reg[in_idx];
        end
    end

    // entries never written read as blocked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= '0;
        end else if (st_we) begin
            st_vld_reg[st_waddr] <= 1'b1;
        end
    end

    // ready queue memory: push at tail, head read at accept
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        if (accept) begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
    end

    // request sequencing
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        tid_next       = tid_reg;
        status_next    = status_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        st_we          = 1'b0;
        st_waddr       = run_idx;
        st_wdata       = rrts_pkg::TS_RUNNING;
        fifo_we        = 1'b0;
        fifo_waddr     = tail_reg;
        fifo_wdata     = run_id_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next   = rrts_pkg::req_t'(s_tuser);
                    tid_next   = s_tdata[rrts_pkg::TID_W-1:0];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = rrts_pkg::ST_OK;
                state_next  = S_RESP;
                unique case (req_reg) inside
                    rrts_pkg::REQ_ENQ: begin
                        if (!tid_ok || eff_state == rrts_pkg::TS_DEAD) begin
                            status_next = rrts_pkg::ST_DEAD;
                        end else if ((run_valid_reg && run_id_reg == tid_reg) ||
                                     eff_state == rrts_pkg::TS_READY ||
                                     eff_state == rrts_pkg::TS_RUNNING) begin
                            status_next = rrts_pkg::ST_DUP;
                        end else begin
                            st_we      = 1'b1;
                            st_waddr   = tid_idx;
                            st_wdata   = rrts_pkg::TS_READY;
                            fifo_we    = 1'b1;
                            fifo_wdata = tid_reg;
                            tail_next  = ptr_inc(tail_reg);
                            cnt_next   = CNT_W'(cnt_reg + 1'b1);
                        end
                    end
                    rrts_pkg::REQ_YIELD: begin
                        // empty queue: the running thread keeps running
                        if (has_q) begin
                            head_next      = ptr_inc(head_reg);
                            run_valid_next = 1'b1;
                            run_id_next    = fifo_rd_reg;
                            state_next     = S_DISP;
                            if (run_valid_reg) begin
                                st_we     = 1'b1;
                                st_wdata  = rrts_pkg::TS_READY;
                                fifo_we   = 1'b1;
                                tail_next = ptr_inc(tail_reg);
                            end else begin
                                cnt_next = CNT_W'(cnt_reg - 1'b1);
                            end
                        end
                    end
                    rrts_pkg::REQ_BLOCK, rrts_pkg::REQ_EXIT: begin
                        if (run_valid_reg) begin
                            st_we    = 1'b1;
                            st_wdata = (req_reg == rrts_pkg::REQ_BLOCK) ?
                                       rrts_pkg::TS_BLOCKED : rrts_pkg::TS_DEAD;
                            if (has_q) begin
                                head_next   = ptr_inc(head_reg);
                                cnt_next    = CNT_W'(cnt_reg - 1'b1);
                                run_id_next = fifo_rd_reg;
                                state_next  = S_DISP;
                            end else begin
                                run_valid_next = 1'b0;
                                run_id_next    = '0;
                            end
                        end
                    end
                    default: begin
                        // query and unused codes change nothing
                    end
                endcase
            end
            S_DISP: begin
                // mark the dispatched thread running
                st_we      = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000,
                                     !run_valid_reg && !has_q,
                                     rrts_pkg::COUNT_W'(cnt_reg),
                                     run_valid_reg ? run_id_reg : 4'd0,
                                     run_valid_reg,
                                     status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        req_reg     <= req_next;
        tid_reg     <= tid_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    // queue never holds more entries than threads
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) <= NUM_THREADS)
        else $error("ready queue count out of range");

    // no running thread means the reported number is zero
    a_idle_id: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_valid_reg |-> run_id_reg == '0)
        else $error("stale running thread number");

    // memory writes never overlap an accept-cycle read
    a_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_we || fifo_we) |-> state_reg != S_IDLE)
        else $error("memory write during accept");

    // a successful enqueue grows the queue by one
    a_enq_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && req_reg == rrts_pkg::REQ_ENQ &&
         status_next == rrts_pkg::ST_OK)
        |=> int'(cnt_reg) == int'($past(cnt_reg)) + 1)
        else $error("enqueue did not grow the queue");
`endif

endmodule

// ===== dv/tb_round_robin_thread_scheduler.sv =====
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler;

    localparam int N_THREADS   = 16;
    localparam int RAND_ITEMS  = 1200;
    localparam int CALM_ITEMS  = 150;   // final stretch with no idling
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int STUCK_LIMIT = 2000;  // cycles with no item moving
    localparam int DRAIN_WAIT  = 20;

    // expected result item
    typedef struct {
        rrts_pkg::status_t                status;
        logic                             cur_valid;
        logic [rrts_pkg::TID_W-1:0]       cur_thread;
        logic [rrts_pkg::COUNT_W-1:0]     queue_len;
        logic                             sched_empty;
    } sched_view_t;

    // scheduler shadow: thread table, ready ring, running thread
    class sched_scoreboard;
        rrts_pkg::tstate_t          thr_state[N_THREADS];
        logic [rrts_pkg::TID_W-1:0] ready_ring[N_THREADS];
        int unsigned                head;
        int unsigned                tail;
        int unsigned                count;
        bit                         run_valid;
        logic [rrts_pkg::TID_W-1:0] run_id;
        sched_view_t                expected_q[$];
        int                         errors;

        function new();
            foreach (thr_state[i]) begin
                thr_state[i]  = rrts_pkg::TS_BLOCKED;
                ready_ring[i] = '0;
            end
            head      = 0;
            tail      = 0;
            count     = 0;
            run_valid = 0;
            run_id    = '0;
            errors    = 0;
        endfunction

        function void push_ready(logic [rrts_pkg::TID_W-1:0] id);
            if (count >= N_THREADS)
                return;
            ready_ring[tail] = id;
            tail  = (tail + 1) % N_THREADS;
            count = count + 1;
        endfunction

        // requeue a still-running thread, then pop until a ready one is found
        function void dispatch_head();
            logic [rrts_pkg::TID_W-1:0] cand;
            bit                         found;
            if (run_valid && thr_state[run_id] == rrts_pkg::TS_RUNNING) begin
                thr_state[run_id] = rrts_pkg::TS_READY;
                push_ready(run_id);
            end
            run_valid = 0;
            run_id    = '0;
            found     = 0;
            while (count > 0 && !found) begin
                cand  = ready_ring[head];
                head  = (head + 1) % N_THREADS;
                count = count - 1;
                if (thr_state[cand] == rrts_pkg::TS_READY) begin
                    thr_state[cand] = rrts_pkg::TS_RUNNING;
                    run_valid = 1;
                    run_id    = cand;
                    found     = 1;
                end
            end
        endfunction

        // block or exit: only acts when a thread is running
        function void retire_running(rrts_pkg::tstate_t new_state);
            if (!run_valid)
                return;
            thr_state[run_id] = new_state;
            run_valid = 0;
            run_id    = '0;
            dispatch_head();
        endfunction

        function void note_request(logic [2:0] kind, logic [rrts_pkg::TID_W-1:0] tid);
            rrts_pkg::status_t st;
            sched_view_t       view;
            st = rrts_pkg::ST_OK;
            case (kind)
                rrts_pkg::REQ_ENQ: begin
                    if (int'(tid) >= N_THREADS || thr_state[tid] == rrts_pkg::TS_DEAD) begin
                        st = rrts_pkg::ST_DEAD;
                    end else if ((run_valid && run_id == tid) ||
                                 thr_state[tid] == rrts_pkg::TS_READY ||
                                 thr_state[tid] == rrts_pkg::TS_RUNNING) begin
                        st = rrts_pkg::ST_DUP;
                    end else begin
                        thr_state[tid] = rrts_pkg::TS_READY;
                        push_ready(tid);
                    end
                end
                rrts_pkg::REQ_YIELD: dispatch_head();
                rrts_pkg::REQ_BLOCK: retire_running(rrts_pkg::TS_BLOCKED);
                rrts_pkg::REQ_EXIT:  retire_running(rrts_pkg::TS_DEAD);
                default: ;  // query and unused codes change nothing
            endcase
            view.status      = st;
            view.cur_valid   = run_valid;
            view.cur_thread  = run_valid ? run_id : '0;
            view.queue_len   = rrts_pkg::COUNT_W'(count);
            view.sched_empty = (!run_valid && count == 0);
            expected_q.insert(expected_q.size(), view);
        endfunction

        function void check_result(logic [15:0] data);
            sched_view_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result 0x%04h with no request pending", $time, data);
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (data[1:0] !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, data[1:0]);
                errors++;
            end
            if (data[2] !== want.cur_valid) begin
                $display("%0t: current_valid expected %0d actual %0d",
                         $time, want.cur_valid, data[2]);
                errors++;
            end
            if (data[6:3] !== want.cur_thread) begin
                $display("%0t: current_thread expected %0d actual %0d",
                         $time, want.cur_thread, data[6:3]);
                errors++;
            end
            if (data[11:7] !== want.queue_len) begin
                $display("%0t: queue_len expected %0d actual %0d",
                         $time, want.queue_len, data[11:7]);
                errors++;
            end
            if (data[12] !== want.sched_empty) begin
                $display("%0t: sched_empty expected %0d actual %0d",
                         $time, want.sched_empty, data[12]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [3:0] thread_id, [7:4] zero
    logic [2:0]  s_tuser  = '0;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [1:0] status, [2] current_valid, [6:3] current_thread,
                                  // [11:7] queue_len, [12] sched_empty, [15:13] zero

    sched_scoreboard sb = new();
    bit tx_idle_on = 1;
    bit rx_idle_on = 1;
    bit hold_go    = 0;
    int stuck_cycles = 0;

    round_robin_thread_scheduler #(.NUM_THREADS(N_THREADS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // offer one request item, with an optional idle burst ahead of it
    task automatic send_request(logic [2:0] kind, logic [rrts_pkg::TID_W-1:0] tid);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, tid};
        do @(posedge aclk); while (!s_tready);
    endtask

    // item monitors on both channels
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[3:0]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // watchdog: nothing moving for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result receiver: random stall bursts and one long hold-off
    initial begin
        int held;
        bit hold_done;
        hold_done = 0;
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1;
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // stimulus
    initial begin
        int                         pick;
        int                         exits_left;
        logic [2:0]                 kind;
        logic [rrts_pkg::TID_W-1:0] tid;

        exits_left = 12;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty scheduler, duplicates, dead thread, unused codes
        send_request(rrts_pkg::REQ_QUERY, 4'd0);
        send_request(rrts_pkg::REQ_YIELD, 4'd0);   // nothing running, queue empty
        send_request(rrts_pkg::REQ_BLOCK, 4'd0);   // nothing running
        send_request(rrts_pkg::REQ_EXIT,  4'd0);
        send_request(rrts_pkg::REQ_ENQ,   4'd0);
        send_request(rrts_pkg::REQ_ENQ,   4'd15);
        send_request(rrts_pkg::REQ_ENQ,   4'd0);   // already queued
        send_request(rrts_pkg::REQ_BLOCK, 4'd0);   // nothing running, queue not empty
        send_request(rrts_pkg::REQ_EXIT,  4'd0);
        send_request(rrts_pkg::REQ_YIELD, 4'd0);   // dispatch from idle
        send_request(rrts_pkg::REQ_ENQ,   4'd0);   // already running
        send_request(rrts_pkg::REQ_YIELD, 4'd0);   // rotate
        send_request(rrts_pkg::REQ_EXIT,  4'd0);   // thread 15 dies
        send_request(rrts_pkg::REQ_ENQ,   4'd15);  // dead thread
        send_request(rrts_pkg::REQ_YIELD, 4'd0);   // queue empty, keeps running
        send_request(rrts_pkg::REQ_BLOCK, 4'd0);
        send_request(rrts_pkg::REQ_ENQ,   4'd10);
        send_request(rrts_pkg::REQ_ENQ,   4'd5);
        send_request(3'd5,                4'd15);
        send_request(3'd6,                4'd0);
        send_request(3'd7,                4'd9);
        send_request(rrts_pkg::REQ_ENQ,   4'd0);   // wake a blocked thread
        send_request(rrts_pkg::REQ_YIELD, 4'd3);

        // random traffic, enqueue heavy so the ready queue stays busy
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 300)
                hold_go = 1;
            if (i == RAND_ITEMS - CALM_ITEMS) begin
                tx_idle_on = 0;
                rx_idle_on = 0;
            end
            pick = $urandom_range(0, 99);
            tid  = rrts_pkg::TID_W'($urandom_range(0, N_THREADS - 1));
            if (pick < 48)
                kind = rrts_pkg::REQ_ENQ;
            else if (pick < 73)
                kind = rrts_pkg::REQ_YIELD;
            else if (pick < 88)
                kind = rrts_pkg::REQ_BLOCK;
            else if (pick < 90 && exits_left > 0) begin
                kind = rrts_pkg::REQ_EXIT;
                exits_left--;
            end else if (pick < 97)
                kind = rrts_pkg::REQ_QUERY;
            else
                kind = 3'($urandom_range(5, 7));
            send_request(kind, tid);
        end
        s_tvalid <= 1'b0;

        // drain, then settle
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rrts_pkg.sv
hw/rtl/round_robin_thread_scheduler.sv
dv/tb_round_robin_thread_scheduler.sv
